// ===== src/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// Display status timing package
// Timing constants, status bit layout and the result record shared by the
// display status timing block.
// ----------------------------------------------------------------------------
package dst_pkg;

    // Timing in machine cycles
    localparam logic [63:0] H_VISIBLE = 64'd960;
    localparam logic [63:0] H_TOTAL   = 64'd1232;
    localparam logic [63:0] V_VISIBLE = 64'd197120;
    localparam logic [63:0] V_TOTAL   = 64'd280896;

    // Scanlines per frame and the vblank end deadline loaded at reset
    localparam logic [8:0]  LINES          = 9'd228;
    localparam logic [63:0] VBLANK_END_RST = 64'd227 * H_TOTAL;

    // Field widths
    localparam int ELAPSED_W = 10;
    localparam int LINE_W    = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_HBLANK_IRQ_EN = 2'd0;
    localparam logic [1:0] REG_VBLANK_IRQ_EN = 2'd1;
    localparam logic [1:0] REG_VCOUNT_IRQ_EN = 2'd2;
    localparam logic [1:0] REG_VCOUNT_TARGET = 2'd3;

    // One result record
    typedef struct packed {
        logic              hblank_flag;
        logic              vblank_flag;
        logic              vcount_match_flag;
        logic [LINE_W-1:0] scanline;
        logic              hblank_irq;
        logic              vblank_irq;
        logic              vcount_irq;
        logic              hblank_event;
        logic              vblank_event;
        logic              render_request;
        logic [LINE_W-1:0] render_line;
    } result_t;

    // Next line number, wrapping at LINES
    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] line);
        logic [LINE_W:0] wide;
        wide = {1'b0, line} + 9'd1;
        if (wide >= LINES)
            return '0;
        return wide[LINE_W-1:0];
    endfunction

endpackage

// ===== src/display_status_timing.sv =====
// ----------------------------------------------------------------------------
// Display status timing
// Scanline and blanking timing generator: keeps a running cycle count and four
// deadlines, drives status flags, interrupt pulses and line render requests.
// ----------------------------------------------------------------------------
// Each accepted result is registered, in the skid entry if a stalled result holds the output.
// Throughput: one request per cycle unless in_stall; the timing state updates
// in the same cycle the request is taken. A skid entry takes one more request
// while a result waits on out_stall; in_stall holds until the skid moves up.
// Reset: async active low; clears cycle count, status, enables and valid bits,
// loads the first deadlines and parks the scanline on the last line.
module display_status_timing (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          wr_en,
    input  logic [1:0]                    wr_index,
    input  logic [7:0]                    wr_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dst_pkg::ELAPSED_W-1:0] elapsed_cycles,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hblank_flag,
    output logic                          vblank_flag,
    output logic                          vcount_match_flag,
    output logic [dst_pkg::LINE_W-1:0]    scanline,
    output logic                          hblank_irq,
    output logic                          vblank_irq,
    output logic                          vcount_irq,
    output logic                          hblank_event,
    output logic                          vblank_event,
    output logic                          render_request,
    output logic [dst_pkg::LINE_W-1:0]    render_line
);
    import dst_pkg::*;

    // Configuration
    logic              hblank_irq_en_reg;
    logic              vblank_irq_en_reg;
    logic              vcount_irq_en_reg;
    logic [LINE_W-1:0] vcount_target_reg;

    // Timing state
    logic [63:0]       cycle_reg;
    logic [63:0]       hblank_dl_reg;
    logic [63:0]       line_end_dl_reg;
    logic [63:0]       vblank_dl_reg;
    logic [63:0]       vblank_end_dl_reg;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] upcoming_reg;
    logic              st_hblank_reg;
    logic              st_vblank_reg;
    logic              st_vmatch_reg;

    logic [63:0]       cycle_next;
    logic [63:0]       hblank_dl_next;
    logic [63:0]       line_end_dl_next;
    logic [63:0]       vblank_dl_next;
    logic [63:0]       vblank_end_dl_next;
    logic [LINE_W-1:0] line_next;
    logic [LINE_W-1:0] upcoming_next;
    logic              st_hblank_next;
    logic              st_vblank_next;
    logic              st_vmatch_next;

    logic              hit_hblank;
    logic              hit_line_end;
    logic              hit_vblank;
    logic              hit_vblank_end;
    result_t           result;

    // Output buffer
    result_t           out_reg;
    result_t           skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_acc;
    logic              out_free;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Advance the cycle count and check each deadline against it
    always_comb
    begin
        cycle_next     = cycle_reg + {{(64-ELAPSED_W){1'b0}}, elapsed_cycles};
        hit_hblank     = cycle_next >= hblank_dl_reg;
        hit_line_end   = cycle_next >= line_end_dl_reg;
        hit_vblank_end = cycle_next >= vblank_end_dl_reg;
        hit_vblank     = cycle_next >= vblank_dl_reg;

        hblank_dl_next     = hit_hblank     ? hblank_dl_reg + H_TOTAL       : hblank_dl_reg;
        line_end_dl_next   = hit_line_end   ? line_end_dl_reg + H_TOTAL     : line_end_dl_reg;
        vblank_end_dl_next = hit_vblank_end ? vblank_end_dl_reg + V_TOTAL   : vblank_end_dl_reg;
        vblank_dl_next     = hit_vblank     ? vblank_dl_reg + V_TOTAL       : vblank_dl_reg;

        line_next      = line_reg;
        upcoming_next  = upcoming_reg;
        st_hblank_next = st_hblank_reg || hit_hblank;
        st_vmatch_next = st_vmatch_reg;

        // Start a new line: advance the scanline and compare with the target
        if (hit_line_end)
        begin
            line_next      = line_inc(line_reg);
            upcoming_next  = line_inc(line_next);
            st_hblank_next = 1'b0;
            st_vmatch_next = (line_next == vcount_target_reg);
        end

        // Vblank end clears first, vblank start sets after
        st_vblank_next = st_vblank_reg;
        if (hit_vblank_end)
            st_vblank_next = 1'b0;
        if (hit_vblank)
            st_vblank_next = 1'b1;

        result.hblank_flag       = st_hblank_next;
        result.vblank_flag       = st_vblank_next;
        result.vcount_match_flag = st_vmatch_next;
        result.scanline          = line_next;
        result.hblank_irq        = hit_hblank && hblank_irq_en_reg;
        result.vblank_irq        = hit_vblank && vblank_irq_en_reg;
        result.vcount_irq        = hit_line_end && (line_next == vcount_target_reg)
                                   && vcount_irq_en_reg;
        result.hblank_event      = hit_hblank;
        result.vblank_event      = hit_vblank;
        result.render_request    = hit_line_end;
        result.render_line       = hit_line_end ? upcoming_reg : '0;
    end

    // Hold configuration; all four write indexes are mapped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hblank_irq_en_reg <= 1'b0;
            vblank_irq_en_reg <= 1'b0;
            vcount_irq_en_reg <= 1'b0;
            vcount_target_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HBLANK_IRQ_EN: hblank_irq_en_reg <= wr_data[0];
                REG_VBLANK_IRQ_EN: vblank_irq_en_reg <= wr_data[0];
                REG_VCOUNT_IRQ_EN: vcount_irq_en_reg <= wr_data[0];
                REG_VCOUNT_TARGET: vcount_target_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Update timing state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg         <= '0;
            hblank_dl_reg     <= H_VISIBLE;
            line_end_dl_reg   <= '0;
            vblank_dl_reg     <= V_VISIBLE;
            vblank_end_dl_reg <= VBLANK_END_RST;
            line_reg          <= LINE_W'(LINES - 9'd1);
            upcoming_reg      <= '0;
            st_hblank_reg     <= 1'b0;
            st_vblank_reg     <= 1'b0;
            st_vmatch_reg     <= 1'b0;
        end
        else if (in_acc)
        begin
            cycle_reg         <= cycle_next;
            hblank_dl_reg     <= hblank_dl_next;
            line_end_dl_reg   <= line_end_dl_next;
            vblank_dl_reg     <= vblank_dl_next;
            vblank_end_dl_reg <= vblank_end_dl_next;
            line_reg          <= line_next;
            upcoming_reg      <= upcoming_next;
            st_hblank_reg     <= st_hblank_next;
            st_vblank_reg     <= st_vblank_next;
            st_vmatch_reg     <= st_vmatch_next;
        end
    end

    // Output register with a skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_acc)
                out_reg <= result;
        end
        else if (in_acc)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hblank_flag       = out_reg.hblank_flag;
    assign vblank_flag       = out_reg.vblank_flag;
    assign vcount_match_flag = out_reg.vcount_match_flag;
    assign scanline          = out_reg.scanline;
    assign hblank_irq        = out_reg.hblank_irq;
    assign vblank_irq        = out_reg.vblank_irq;
    assign vcount_irq        = out_reg.vcount_irq;
    assign hblank_event      = out_reg.hblank_event;
    assign vblank_event      = out_reg.vblank_event;
    assign render_request    = out_reg.render_request;
    assign render_line       = out_reg.render_line;

endmodule

// ===== src/dst_checker.sv =====
// ----------------------------------------------------------------------------
// Display status timing checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dst_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic hblank_flag,
    input logic vblank_flag,
    input logic vcount_match_flag,
    input logic hblank_irq,
    input logic vcount_irq,
    input logic hblank_event,
    input logic vblank_event,
    input logic render_request
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Hblank interrupt only with the hblank start event
    a_hirq_evt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hblank_irq |-> hblank_event)
        else $error("hblank interrupt without hblank start");

    // Vcount interrupt only on a new line that matches
    a_virq_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vcount_irq |-> render_request && vcount_match_flag)
        else $error("vcount interrupt without matching new line");

    // A new line leaves hblank cleared
    a_line_hclr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && render_request |-> !hblank_flag)
        else $error("hblank flag set after line start");

    // Vblank start leaves the vblank flag set
    a_vblank_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_event |-> vblank_flag)
        else $error("vblank flag clear after vblank start");

endmodule

bind display_status_timing dst_checker u_dst_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .hblank_flag       (hblank_flag),
    .vblank_flag       (vblank_flag),
    .vcount_match_flag (vcount_match_flag),
    .hblank_irq        (hblank_irq),
    .vcount_irq        (vcount_irq),
    .hblank_event      (hblank_event),
    .vblank_event      (vblank_event),
    .render_request    (render_request)
);
